[rtl/terminal_padding_expander_core_defines.svh]
// ----------------------------------------------------------------------------
// Terminal padding expander assertion macros
// Shared property forms used by the checker, clocked on clk and disabled
// during reset.
// ----------------------------------------------------------------------------
`ifndef TERMINAL_PADDING_EXPANDER_CORE_DEFINES_SVH
`define TERMINAL_PADDING_EXPANDER_CORE_DEFINES_SVH

// Same-cycle implication.
`define TPE_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("terminal padding expander: same-cycle check failed");

// Next-cycle implication.
`define TPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("terminal padding expander: next-cycle check failed");

`endif

[rtl/tpe_pkg.sv]
// ----------------------------------------------------------------------------
// Terminal padding expander package
// Types, character codes and sizing constants shared by the expander files.
// ----------------------------------------------------------------------------
package tpe_pkg;

    localparam int MAX_PAD_DIGITS = 5;
    localparam int DIGIT_LIMIT    = (MAX_PAD_DIGITS > 9) ? 9 : MAX_PAD_DIGITS;
    localparam logic [4:0] DIGIT_FULL = 5'(DIGIT_LIMIT + 2);

    localparam logic [16:0] MILLIS_MAX  = 17'd131071;
    localparam logic [15:0] RECIP_10    = 16'd52429;
    localparam int          RECIP_SHIFT = 19;
    localparam int          QUOT_W      = 10;
    localparam int          REPLAY_DEPTH = 16;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_NULL = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_HIGH   = 8'h80;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic REG_BAUD_SHIFT = 1'b0;
    localparam logic REG_XON_XOFF   = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DOLLAR,
        PH_DIGITS,
        PH_DOT,
        PH_STAR,
        PH_SLASH,
        PH_CLOSE
    } phase_t;

    typedef enum logic [1:0] {
        S_ITEM,
        S_PAD,
        S_EMIT,
        S_REPLAY
    } seq_state_t;

    typedef enum logic [2:0] {
        P_IDLE,
        P_MS,
        P_T,
        P_DIV,
        P_SHIFT,
        P_DONE
    } pad_step_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_SINGLE,
        ACT_PAD,
        ACT_REPLAY
    } act_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_DIRECT,
        OUT_FIN,
        OUT_REPLAY
    } out_sel_t;

    typedef struct packed {
        logic [16:0] millis;
        logic [3:0]  tenths;
        logic        per_line;
        logic        mandatory;
        logic [9:0]  affected;
    } pad_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] count;
    } pad_stat_t;

endpackage

[rtl/tpe_pad_unit.sv]
// ----------------------------------------------------------------------------
// Pad count unit
// Computes the NUL pad count of one padding spec in five steps around a
// single shared multiplier; the shift step applies the baud shift and saturation.
// ----------------------------------------------------------------------------
module tpe_pad_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tpe_pkg::pad_req_t   req,
    input  logic signed [4:0]   baud_shift,
    input  logic                xon_xoff_on,
    output tpe_pkg::pad_stat_t  stat
);
    import tpe_pkg::*;

    pad_step_t   step_reg;
    pad_step_t   step_next;
    pad_req_t    req_reg;
    logic [26:0] acc_reg;
    logic [26:0] acc_next;
    logic [13:0] tprod_reg;
    logic [13:0] tprod_next;
    logic [31:0] count_reg;
    logic [31:0] count_next;
    logic [16:0] mul_a;
    logic [15:0] mul_b;
    logic [32:0] prod;
    logic        use_lines;
    logic        has_tenths;
    logic [3:0]  r_amt;
    logic [4:0]  l_amt;
    logic [26:0] r_mask;
    logic [26:0] r_res;
    logic [42:0] l_wide;
    logic [31:0] shift_res;

    assign use_lines  = req_reg.per_line && (req_reg.affected != 10'd0);
    assign has_tenths = (req_reg.tenths != 4'd0);
    assign prod       = {16'b0, mul_a} * {17'b0, mul_b};

    assign r_amt  = baud_shift[3:0];
    assign l_amt  = ~baud_shift[4:0] + 5'd1;
    assign r_mask = ~({27{1'b1}} << r_amt);
    assign r_res  = (acc_reg >> r_amt) + {26'b0, |(acc_reg & r_mask)};
    assign l_wide = {16'b0, acc_reg} << l_amt;

    always_comb
    begin
        priority if (!req_reg.mandatory && xon_xoff_on)
        begin
            shift_res = 32'd0;
        end
        else if (baud_shift[4])
        begin
            shift_res = (|l_wide[42:32]) ? {32{1'b1}} : l_wide[31:0];
        end
        else if (r_amt != 4'd0)
        begin
            shift_res = {5'b0, r_res};
        end
        else
        begin
            shift_res = {5'b0, acc_reg};
        end
    end

    always_comb
    begin
        step_next = step_reg;
        unique case (step_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    step_next = P_MS;
                end
            end
            P_MS:    step_next = P_T;
            P_T:     step_next = P_DIV;
            P_DIV:   step_next = P_SHIFT;
            P_SHIFT: step_next = P_DONE;
            P_DONE:  step_next = P_IDLE;
            default: step_next = P_IDLE;
        endcase
    end

    always_comb
    begin
        mul_a      = 17'd0;
        mul_b      = 16'd0;
        acc_next   = acc_reg;
        tprod_next = tprod_reg;
        count_next = count_reg;
        unique case (step_reg)
            P_MS:
            begin
                mul_a    = req_reg.millis;
                mul_b    = {6'b0, req_reg.affected};
                acc_next = use_lines ? prod[26:0] : {10'b0, req_reg.millis};
            end
            P_T:
            begin
                mul_a      = {13'b0, req_reg.tenths};
                mul_b      = {6'b0, req_reg.affected};
                tprod_next = prod[13:0];
            end
            P_DIV:
            begin
                mul_a    = {3'b0, tprod_reg};
                mul_b    = RECIP_10;
                acc_next = acc_reg
                         + (use_lines ? {17'b0, prod[RECIP_SHIFT +: QUOT_W]} : 27'd0)
                         + {26'b0, has_tenths};
            end
            P_SHIFT:
            begin
                count_next = shift_res;
            end
            default:
            begin
                mul_a = 17'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= P_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_reg == P_IDLE && start)
        begin
            req_reg <= req;
        end
        acc_reg   <= acc_next;
        tprod_reg <= tprod_next;
        count_reg <= count_next;
    end

    assign stat.done  = (step_reg == P_DONE);
    assign stat.count = count_reg;

endmodule

[rtl/terminal_padding_expander_core.sv]
// ----------------------------------------------------------------------------
// Terminal padding expander core
// Expands terminal capability strings into data bytes, NUL pad runs and an
// end marker.
//
// Input beats carry byte_in and affected_count on item_valid/item_ready.
// Result beats carry kind, out_byte, null_count and last on
// result_valid/result_ready; last marks the final result of an input beat.
// Registers sit on an APB-style port: baud_shift at 0x0, xon_xoff_on at 0x4.
// A plain byte goes into the result register when it is free, else it waits
// in the emit state. Bytes inside a padding spec give no result. A closing
// '>' waits for the five steps of the shared pad multiplier. A broken spec
// replays its buffered bytes, then the byte that broke it, one result per
// cycle while the receiver takes them. The result register lets the next
// beat in while a result waits; a stalled receiver holds the sequencer once a
// further result is due. Reset clears the parser, the registers and result_valid.
// ----------------------------------------------------------------------------
module terminal_padding_expander_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  byte_in,
    input  logic [9:0]  affected_count,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic [31:0] null_count,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tpe_pkg::*;

    seq_state_t        state_reg;
    seq_state_t        state_next;
    phase_t            phase_reg;
    phase_t            phase_next;
    phase_t            dec_phase;
    logic [16:0]       millis_reg;
    logic [16:0]       millis_next;
    logic [3:0]        tenths_reg;
    logic [3:0]        tenths_next;
    logic              per_line_reg;
    logic              per_line_next;
    logic              mandatory_reg;
    logic              mandatory_next;
    logic [4:0]        rlen_reg;
    logic [4:0]        rlen_next;
    logic [3:0]        rp_idx_reg;
    logic [3:0]        rp_idx_next;
    logic [7:0]        buf_reg [REPLAY_DEPTH];
    logic [1:0]        fin_kind_reg;
    logic [7:0]        fin_byte_reg;
    logic signed [4:0] baud_shift_reg;
    logic              xon_xoff_reg;

    logic              result_valid_reg;
    logic              result_valid_next;
    logic [1:0]        kind_reg;
    logic [1:0]        kind_next;
    logic [7:0]        out_byte_reg;
    logic [7:0]        out_byte_next;
    logic [31:0]       null_count_reg;
    logic [31:0]       null_count_next;
    logic              last_reg;
    logic              last_next;

    act_t              act;
    logic              buf_wr;
    logic              spec_clr;
    logic              ms_wr;
    logic              t_wr;
    logic              set_line;
    logic              set_mand;
    logic              chk_star;
    logic              chk_slash;
    logic              chk_close;
    logic              brk;
    logic [1:0]        dec_kind;
    logic [7:0]        dec_byte;
    logic              is_digit;
    logic [20:0]       ms_x10;

    logic              item_fire;
    logic              slot_free;
    logic              rp_last;
    logic              pad_start;
    out_sel_t          out_sel;
    pad_req_t          pad_req;
    pad_stat_t         pad_stat;
    logic              cfg_wr;

    assign item_fire = (state_reg == S_ITEM) && item_valid;
    assign item_ready = (state_reg == S_ITEM);
    assign slot_free = !result_valid_reg || result_ready;
    assign rp_last   = (({1'b0, rp_idx_reg} + 5'd1) == rlen_reg);
    assign is_digit  = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    assign ms_x10    = ({4'b0, millis_reg} << 3) + ({4'b0, millis_reg} << 1)
                     + {17'b0, byte_in[3:0]};

    always_comb
    begin
        act       = ACT_NONE;
        dec_phase = phase_reg;
        buf_wr    = 1'b0;
        spec_clr  = 1'b0;
        ms_wr     = 1'b0;
        t_wr      = 1'b0;
        set_line  = 1'b0;
        set_mand  = 1'b0;
        chk_star  = 1'b0;
        chk_slash = 1'b0;
        chk_close = 1'b0;
        brk       = 1'b0;
        dec_kind  = KIND_DATA;
        dec_byte  = byte_in;
        unique case (phase_reg)
            PH_IDLE:
            begin
                priority if (byte_in == CH_NUL)
                begin
                    act      = ACT_SINGLE;
                    dec_kind = KIND_END;
                end
                else if (byte_in == CH_DOLLAR)
                begin
                    spec_clr  = 1'b1;
                    dec_phase = PH_DOLLAR;
                end
                else
                begin
                    act      = ACT_SINGLE;
                    dec_byte = (byte_in == CH_HIGH) ? CH_NUL : byte_in;
                end
            end
            PH_DOLLAR:
            begin
                if (byte_in == CH_LT)
                begin
                    buf_wr    = 1'b1;
                    dec_phase = PH_DIGITS;
                end
                else
                begin
                    brk = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                priority if (is_digit)
                begin
                    if (rlen_reg >= DIGIT_FULL)
                    begin
                        brk = 1'b1;
                    end
                    else
                    begin
                        ms_wr  = 1'b1;
                        buf_wr = 1'b1;
                    end
                end
                else if (byte_in == CH_DOT)
                begin
                    buf_wr    = 1'b1;
                    dec_phase = PH_DOT;
                end
                else
                begin
                    chk_star = 1'b1;
                end
            end
            PH_DOT:
            begin
                if (is_digit)
                begin
                    t_wr      = 1'b1;
                    buf_wr    = 1'b1;
                    dec_phase = PH_STAR;
                end
                else
                begin
                    chk_star = 1'b1;
                end
            end
            PH_STAR:  chk_star  = 1'b1;
            PH_SLASH: chk_slash = 1'b1;
            PH_CLOSE: chk_close = 1'b1;
            default:  brk       = 1'b1;
        endcase

        if (chk_star)
        begin
            if (byte_in == CH_STAR)
            begin
                set_line  = 1'b1;
                buf_wr    = 1'b1;
                dec_phase = PH_SLASH;
            end
            else
            begin
                chk_slash = 1'b1;
            end
        end
        if (chk_slash)
        begin
            if (byte_in == CH_SLASH)
            begin
                set_mand  = 1'b1;
                buf_wr    = 1'b1;
                dec_phase = PH_CLOSE;
            end
            else
            begin
                chk_close = 1'b1;
            end
        end
        if (chk_close)
        begin
            if (byte_in == CH_GT)
            begin
                act       = ACT_PAD;
                dec_phase = PH_IDLE;
                dec_kind  = KIND_NULL;
                dec_byte  = CH_NUL;
            end
            else
            begin
                brk = 1'b1;
            end
        end
        if (brk)
        begin
            act       = ACT_REPLAY;
            dec_phase = PH_IDLE;
            dec_kind  = (byte_in == CH_NUL) ? KIND_END : KIND_DATA;
            dec_byte  = byte_in;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        millis_next    = millis_reg;
        tenths_next    = tenths_reg;
        per_line_next  = per_line_reg;
        mandatory_next = mandatory_reg;
        rlen_next      = rlen_reg;
        if (item_fire)
        begin
            phase_next = dec_phase;
            if (spec_clr)
            begin
                millis_next    = 17'd0;
                tenths_next    = 4'd0;
                per_line_next  = 1'b0;
                mandatory_next = 1'b0;
                rlen_next      = 5'd1;
            end
            else if (buf_wr && !rlen_reg[4])
            begin
                rlen_next = rlen_reg + 5'd1;
            end
            if (ms_wr)
            begin
                millis_next = (ms_x10 > {4'b0, MILLIS_MAX}) ? MILLIS_MAX : ms_x10[16:0];
            end
            if (t_wr)
            begin
                tenths_next = byte_in[3:0];
            end
            if (set_line)
            begin
                per_line_next = 1'b1;
            end
            if (set_mand)
            begin
                mandatory_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_ITEM:
            begin
                if (item_fire)
                begin
                    unique case (act)
                        ACT_NONE:   state_next = S_ITEM;
                        ACT_SINGLE: state_next = slot_free ? S_ITEM : S_EMIT;
                        ACT_PAD:    state_next = S_PAD;
                        ACT_REPLAY: state_next = S_REPLAY;
                    endcase
                end
            end
            S_PAD:
            begin
                if (pad_stat.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = S_ITEM;
                end
            end
            S_REPLAY:
            begin
                if (slot_free && rp_last)
                begin
                    state_next = S_EMIT;
                end
            end
        endcase
    end

    always_comb
    begin
        pad_start   = 1'b0;
        out_sel     = OUT_NONE;
        rp_idx_next = rp_idx_reg;
        unique case (state_reg)
            S_ITEM:
            begin
                if (item_fire)
                begin
                    rp_idx_next = 4'd0;
                    if (act == ACT_SINGLE && slot_free)
                    begin
                        out_sel = OUT_DIRECT;
                    end
                    if (act == ACT_PAD)
                    begin
                        pad_start = 1'b1;
                    end
                end
            end
            S_PAD:
            begin
                out_sel = OUT_NONE;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_sel = OUT_FIN;
                end
            end
            S_REPLAY:
            begin
                if (slot_free)
                begin
                    out_sel     = OUT_REPLAY;
                    rp_idx_next = rp_idx_reg + 4'd1;
                end
            end
        endcase
    end

    always_comb
    begin
        kind_next       = kind_reg;
        out_byte_next   = out_byte_reg;
        null_count_next = null_count_reg;
        last_next       = last_reg;
        unique case (out_sel)
            OUT_NONE:
            begin
                last_next = last_reg;
            end
            OUT_DIRECT:
            begin
                kind_next       = dec_kind;
                out_byte_next   = dec_byte;
                null_count_next = 32'd0;
                last_next       = 1'b1;
            end
            OUT_FIN:
            begin
                kind_next       = fin_kind_reg;
                out_byte_next   = fin_byte_reg;
                null_count_next = (fin_kind_reg == KIND_NULL) ? pad_stat.count : 32'd0;
                last_next       = 1'b1;
            end
            OUT_REPLAY:
            begin
                kind_next       = KIND_DATA;
                out_byte_next   = buf_reg[rp_idx_reg];
                null_count_next = 32'd0;
                last_next       = 1'b0;
            end
        endcase
        if (out_sel != OUT_NONE)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    assign pad_req.millis    = millis_reg;
    assign pad_req.tenths    = tenths_reg;
    assign pad_req.per_line  = per_line_reg;
    assign pad_req.mandatory = mandatory_reg;
    assign pad_req.affected  = affected_count;

    tpe_pad_unit u_pad_unit (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (pad_start),
        .req         (pad_req),
        .baud_shift  (baud_shift_reg),
        .xon_xoff_on (xon_xoff_reg),
        .stat        (pad_stat)
    );

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            REG_BAUD_SHIFT: prdata = {27'b0, baud_shift_reg[4:0]};
            REG_XON_XOFF:   prdata = {31'b0, xon_xoff_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baud_shift_reg <= 5'sd0;
            xon_xoff_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_BAUD_SHIFT: baud_shift_reg <= pwdata[4:0];
                REG_XON_XOFF:   xon_xoff_reg   <= pwdata[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_ITEM;
            phase_reg        <= PH_IDLE;
            millis_reg       <= 17'd0;
            tenths_reg       <= 4'd0;
            per_line_reg     <= 1'b0;
            mandatory_reg    <= 1'b0;
            rlen_reg         <= 5'd0;
            rp_idx_reg       <= 4'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            millis_reg       <= millis_next;
            tenths_reg       <= tenths_next;
            per_line_reg     <= per_line_next;
            mandatory_reg    <= mandatory_next;
            rlen_reg         <= rlen_next;
            rp_idx_reg       <= rp_idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire && (spec_clr || (buf_wr && !rlen_reg[4])))
        begin
            buf_reg[spec_clr ? 4'd0 : rlen_reg[3:0]] <= byte_in;
        end
        if (item_fire)
        begin
            fin_kind_reg <= dec_kind;
            fin_byte_reg <= dec_byte;
        end
        kind_reg       <= kind_next;
        out_byte_reg   <= out_byte_next;
        null_count_reg <= null_count_next;
        last_reg       <= last_next;
    end

    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign out_byte     = out_byte_reg;
    assign null_count   = null_count_reg;
    assign last         = last_reg;

endmodule

[rtl/tpe_checker.sv]
// ----------------------------------------------------------------------------
// Terminal padding expander checker
// Watches the result channel of the expander core for stall and field rules.
// ----------------------------------------------------------------------------
`include "terminal_padding_expander_core_defines.svh"

module tpe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic [1:0]  kind,
    input logic [7:0]  out_byte,
    input logic [31:0] null_count,
    input logic        last
);
    import tpe_pkg::*;

    `TPE_ASSERT_NEXT(a_stall_hold, result_valid && !result_ready,
        result_valid && $stable(kind) && $stable(out_byte) && $stable(null_count))
    `TPE_ASSERT_IMPLY(a_tail_is_last, result_valid && kind != KIND_DATA, last)
    `TPE_ASSERT_IMPLY(a_count_only_null, result_valid && kind != KIND_NULL,
        null_count == 32'd0)
    `TPE_ASSERT_IMPLY(a_byte_only_data, result_valid && kind != KIND_DATA,
        out_byte == 8'd0)

endmodule

bind terminal_padding_expander_core tpe_checker u_tpe_checker (.*);

[bench/terminal_padding_expander_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal padding expander core testbench
// Sends capability string bytes through the input handshake and checks every
// result beat against a predictor of the expander that runs alongside it.
// Directed strings cover the extreme bytes and the padding spec forms. Random
// traffic then mixes well-formed and broken specs under several register
// settings, with random idling on both sides and one long receiver stall.
// ----------------------------------------------------------------------------
module terminal_padding_expander_core_tb;

    import tpe_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [31:0] nulls;
        logic        last;
    } expand_result_t;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        item_valid     = 1'b0;
    logic        item_ready;
    logic [7:0]  byte_in        = 8'h00;
    logic [9:0]  affected_count = 10'd0;
    logic        result_valid;
    logic        result_ready   = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [31:0] null_count;
    logic        last;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = 3'd0;
    logic [31:0] pwdata         = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    expand_result_t pending_results[$];
    int             mismatch_count = 0;
    int             items_sent     = 0;
    bit             tx_fast        = 1'b0;
    bit             rx_fast        = 1'b0;
    int             rx_hold_cycles = 0;

    logic signed [4:0] baud_cfg   = 5'sd0;
    logic              xon_cfg    = 1'b0;
    phase_t            spec_phase = PH_IDLE;
    logic [16:0]       spec_millis;
    logic [3:0]        spec_tenths;
    logic              spec_per_line;
    logic              spec_mandatory;
    logic [7:0]        spec_buf [REPLAY_DEPTH];
    int                spec_len = 0;

    terminal_padding_expander_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .byte_in        (byte_in),
        .affected_count (affected_count),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .kind           (kind),
        .out_byte       (out_byte),
        .null_count     (null_count),
        .last           (last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [31:0] null_run_length(input logic [9:0] lines);
        logic [63:0] ms;
        logic [63:0] chars;
        int          sh;
        ms = 64'(spec_millis);
        if (spec_millis == 0 && spec_tenths == 0)
            return 32'd0;
        if (!spec_mandatory && xon_cfg)
            return 32'd0;
        if (spec_per_line && lines != 0)
        begin
            ms = ms * 64'(lines);
            if (spec_tenths != 0)
                ms = ms + (64'(spec_tenths) * 64'(lines)) / 64'd10;
        end
        if (spec_tenths != 0)
            ms = ms + 64'd1;
        sh = int'(baud_cfg);
        if (sh > 0)
        begin
            chars = ms >> sh;
            if ((chars << sh) != ms)
                chars = chars + 64'd1;
        end
        else if (sh < 0)
            chars = ms << (-sh);
        else
            chars = ms;
        if (chars > 64'hFFFF_FFFF)
            chars = 64'hFFFF_FFFF;
        return chars[31:0];
    endfunction

    function automatic void push_result(input logic [1:0] k, input logic [7:0] d,
                                        input logic [31:0] n, input logic l);
        expand_result_t r;
        r.kind  = k;
        r.data  = d;
        r.nulls = n;
        r.last  = l;
        pending_results.push_back(r);
    endfunction

    function automatic void hold_spec_byte(input logic [7:0] c);
        if (spec_len < REPLAY_DEPTH)
        begin
            spec_buf[spec_len] = c;
            spec_len++;
        end
    endfunction

    function automatic void expand_byte(input logic [7:0] c, input logic [9:0] lines);
        phase_t ph;
        bit     broken;
        bit     is_digit;
        int     v;
        ph       = spec_phase;
        broken   = 1'b0;
        is_digit = (c >= CH_ZERO && c <= CH_NINE);
        if (ph == PH_IDLE)
        begin
            if (c == CH_NUL)
                push_result(KIND_END, 8'h00, 32'd0, 1'b1);
            else if (c == CH_DOLLAR)
            begin
                spec_len = 0;
                hold_spec_byte(c);
                spec_millis    = '0;
                spec_tenths    = '0;
                spec_per_line  = 1'b0;
                spec_mandatory = 1'b0;
                spec_phase     = PH_DOLLAR;
            end
            else if (c == CH_HIGH)
                push_result(KIND_DATA, CH_NUL, 32'd0, 1'b1);
            else
                push_result(KIND_DATA, c, 32'd0, 1'b1);
            return;
        end
        if (ph == PH_DOLLAR)
        begin
            if (c == CH_LT)
            begin
                hold_spec_byte(c);
                spec_phase = PH_DIGITS;
                return;
            end
            broken = 1'b1;
        end
        if (!broken && ph == PH_DIGITS)
        begin
            if (is_digit)
            begin
                if (spec_len - 2 >= DIGIT_LIMIT)
                    broken = 1'b1;
                else
                begin
                    v = int'(spec_millis) * 10 + int'(c - CH_ZERO);
                    spec_millis = (v > int'(MILLIS_MAX)) ? MILLIS_MAX : 17'(v);
                    hold_spec_byte(c);
                    return;
                end
            end
            else if (c == CH_DOT)
            begin
                hold_spec_byte(c);
                spec_phase = PH_DOT;
                return;
            end
            else
                ph = PH_STAR;
        end
        if (!broken && ph == PH_DOT)
        begin
            if (is_digit)
            begin
                spec_tenths = 4'(c - CH_ZERO);
                hold_spec_byte(c);
                spec_phase = PH_STAR;
                return;
            end
            ph = PH_STAR;
        end
        if (!broken && ph == PH_STAR)
        begin
            if (c == CH_STAR)
            begin
                spec_per_line = 1'b1;
                hold_spec_byte(c);
                spec_phase = PH_SLASH;
                return;
            end
            ph = PH_SLASH;
        end
        if (!broken && ph == PH_SLASH)
        begin
            if (c == CH_SLASH)
            begin
                spec_mandatory = 1'b1;
                hold_spec_byte(c);
                spec_phase = PH_CLOSE;
                return;
            end
            ph = PH_CLOSE;
        end
        if (!broken && ph == PH_CLOSE && c == CH_GT)
        begin
            push_result(KIND_NULL, 8'h00, null_run_length(lines), 1'b1);
            spec_phase = PH_IDLE;
            spec_len   = 0;
            return;
        end
        // A broken spec leaves its held bytes verbatim, then the byte that broke it.
        for (int i = 0; i < spec_len; i++)
            push_result(KIND_DATA, spec_buf[i], 32'd0, 1'b0);
        if (c == CH_NUL)
            push_result(KIND_END, 8'h00, 32'd0, 1'b1);
        else
            push_result(KIND_DATA, c, 32'd0, 1'b1);
        spec_phase = PH_IDLE;
        spec_len   = 0;
    endfunction

    function automatic logic [9:0] random_lines();
        case ($urandom_range(0, 9))
            0: return 10'd0;
            1: return 10'd1023;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [7:0] break_byte();
        case ($urandom_range(0, 5))
            0: return CH_NUL;
            1: return CH_HIGH;
            2: return CH_DOLLAR;
            3: return CH_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic send_item(input logic [7:0] c, input logic [9:0] lines);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid     <= 1'b1;
        byte_in        <= c;
        affected_count <= lines;
        do
            @(posedge clk);
        while (!item_ready);
        expand_byte(c, lines);
        items_sent++;
    endtask

    task automatic send_text(input string txt, input logic [9:0] lines);
        for (int i = 0; i < txt.len(); i++)
            send_item(8'(txt[i]), lines);
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_register(input logic reg_sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_BAUD_SHIFT)
            baud_cfg = value[4:0];
        else
            xon_cfg = value[0];
    endtask

    task automatic send_spec(input bit closed);
        logic [7:0] spec[$];
        int         ndig;
        int         cut;
        logic [9:0] lines;
        lines = random_lines();
        spec.push_back(CH_DOLLAR);
        spec.push_back(CH_LT);
        ndig = closed ? $urandom_range(0, DIGIT_LIMIT) : $urandom_range(0, DIGIT_LIMIT + 2);
        repeat (ndig) spec.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0)
        begin
            spec.push_back(CH_DOT);
            if ($urandom_range(0, 3) != 0)
                spec.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 1) == 1)
            spec.push_back(CH_STAR);
        if ($urandom_range(0, 1) == 1)
            spec.push_back(CH_SLASH);
        if (closed)
        begin
            spec.push_back(CH_GT);
            cut = spec.size();
        end
        else
            cut = $urandom_range(1, spec.size());
        for (int i = 0; i < cut; i++)
            send_item(spec[i], lines);
        if (!closed)
            send_item(break_byte(), lines);
    endtask

    task automatic run_random_traffic(input int n_items);
        int target;
        int pick;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            tx_fast = ($urandom_range(0, 4) == 0);
            rx_fast = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 5)
                send_spec(1'b1);
            else if (pick < 7)
                send_spec(1'b0);
            else if (pick < 9)
                send_item(8'($urandom_range(1, 255)), random_lines());
            else
                send_item(CH_NUL, random_lines());
        end
        send_item(CH_NUL, random_lines());
        tx_fast = 1'b0;
        rx_fast = 1'b0;
    endtask

    task automatic run_setting(input logic signed [4:0] shift, input logic xon,
                               input int n_items);
        wait_idle();
        write_register(REG_BAUD_SHIFT, {{27{shift[4]}}, shift});
        write_register(REG_XON_XOFF, {31'd0, xon});
        run_random_traffic(n_items);
    endtask

    task automatic test_plain_bytes();
        send_item(CH_NUL, 10'd0);
        send_item(CH_HIGH, 10'd1023);
        send_item(8'hFF, 10'd1023);
        send_item(8'h41, 10'd0);
    endtask

    // Zero padding, per-line padding with tenths, a dot with no digit and a
    // spec with one digit too many.
    task automatic test_padding_specs();
        send_text("$<0>", 10'd1023);
        send_text("$<9.5*/>", 10'd1023);
        send_text("$<.>", 10'd0);
        send_text("$<123456", 10'd1023);
    endtask

    task automatic test_register_settings();
        int shift;
        run_setting(-5'sd8, 1'b0, 50);
        run_setting(5'sd15, 1'b1, 50);
        run_setting(-5'sd8, 1'b1, 50);
        run_setting(5'sd15, 1'b0, 50);
        run_setting(5'sd3, 1'b1, 50);
        shift = $urandom_range(0, 23) - 8;
        run_setting(5'(shift), 1'($urandom_range(0, 1)), 50);
    endtask

    task automatic test_stalled_receiver();
        wait_idle();
        rx_hold_cycles = 400;
        tx_fast        = 1'b1;
        rx_fast        = 1'b1;
        repeat (50) send_item(8'($urandom_range(1, 255)), random_lines());
        send_item(CH_NUL, random_lines());
        tx_fast = 1'b0;
        rx_fast = 1'b0;
    endtask

    task automatic test_random_mix();
        run_setting(5'sd0, 1'b0, 70);
    endtask

    initial
    begin
        expand_result_t want;
        expand_result_t got;
        int             stall;
        @(posedge clk);
        forever
        begin
            stall = rx_fast ? 0 : $urandom_range(0, 18);
            if (rx_hold_cycles > 0)
            begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            got.kind  = kind;
            got.data  = out_byte;
            got.nulls = null_count;
            got.last  = last;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat kind %0d byte %02h count %0d last %0b",
                         $time, got.kind, got.data, got.nulls, got.last);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t: expected kind %0d byte %02h count %0d last %0b",
                             $time, want.kind, want.data, want.nulls, want.last);
                    $display("%0t: actual   kind %0d byte %02h count %0d last %0b",
                             $time, got.kind, got.data, got.nulls, got.last);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_bytes();
        test_padding_specs();
        test_register_settings();
        test_stalled_receiver();
        test_random_mix();
        wait_idle();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
